FILE: design/sbb_pkg.sv
// Shared constants, types and helper functions for the separable box blur.
// Used by the controller, the datapath and the top level; depends on nothing.
package sbb_pkg;

  localparam int MAX_WIDTH = 256;
  localparam int MAX_HEIGHT = 256;
  localparam int MAX_RADIUS = 15;
  localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W = $clog2(STORE_DEPTH);
  localparam int CNT_W = ADDR_W + 1;
  localparam int COORD_W = 8;
  localparam int SIZE_W = 9;
  localparam int RAD_W = 4;
  localparam int TAP_W = 5;
  localparam int ACC_W = 13;
  localparam int RECIP_W = 21;
  localparam int RECIP_SHIFT = 20;
  localparam int PROD_W = ACC_W + RECIP_W;
  localparam int PIX_W = 24;

  localparam logic [1:0] CFG_WIDTH = 2'd0;
  localparam logic [1:0] CFG_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_RADIUS = 2'd2;

  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_FETCH = 1'b1;

  typedef struct packed {
    logic load_px;
    logic fetch_early;
    logic h_start;
    logic h_tap;
    logic mul;
    logic h_write;
    logic div_start;
    logic div_step;
    logic v_tap;
    logic v_out;
  } sbb_cmd_t;

  typedef struct packed {
    logic full;
    logic pass_done;
    logic tap_last;
    logic h_last;
    logic div_done;
    logic out_valid;
  } sbb_stat_t;

  // Ceiling of 2^20 / (2r+1); exact truncating division for sums below 8192.
  function automatic logic [RECIP_W-1:0] recip(input logic [RAD_W-1:0] r);
    logic [RECIP_W-1:0] m;
    case (r)
      4'd0: m = 21'd1048576;
      4'd1: m = 21'd349526;
      4'd2: m = 21'd209716;
      4'd3: m = 21'd149797;
      4'd4: m = 21'd116509;
      4'd5: m = 21'd95326;
      4'd6: m = 21'd80660;
      4'd7: m = 21'd69906;
      4'd8: m = 21'd61681;
      4'd9: m = 21'd55189;
      4'd10: m = 21'd49933;
      4'd11: m = 21'd45591;
      4'd12: m = 21'd41944;
      4'd13: m = 21'd38837;
      4'd14: m = 21'd36158;
      4'd15: m = 21'd33826;
      default: m = 21'd33826;
    endcase
    return m;
  endfunction

  // Reflects a window position into 0..n-1 without repeating the border.
  function automatic logic [COORD_W-1:0] reflect(input logic signed [9:0] pos,
                                                 input logic [SIZE_W-1:0] n);
    logic signed [10:0] p;
    logic signed [10:0] ns;
    logic signed [10:0] m;
    p = {pos[9], pos};
    ns = {2'b00, n};
    if (p < 0) begin
      m = -p;
    end else if (p >= ns) begin
      m = ((ns - 11'sd1) <<< 1) - p;
    end else begin
      m = p;
    end
    return m[COORD_W-1:0];
  endfunction

endpackage

FILE: design/sbb_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Self-contained; no package needed.
module sbb_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: design/sbb_ctrl.sv
// Sequencing state machine for loading, the horizontal pass and each fetch.
// Depends on sbb_pkg for the command and status structs.
module sbb_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              action,
  input  logic              out_ready,
  input  sbb_pkg::sbb_stat_t stat,
  output logic              in_ready,
  output sbb_pkg::sbb_cmd_t  cmd
);
  import sbb_pkg::*;

  typedef enum logic [3:0] {
    IDLE, H_TAP, H_DRAIN, H_MUL, H_WR, V_DIV, V_TAP, V_DRAIN, V_MUL, V_OUT
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  assign in_ready = (state == IDLE) && (!stat.out_valid || out_ready);
  assign accept = in_valid && in_ready;

  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      IDLE: begin
        if (accept && action == ACT_LOAD) begin
          cmd.load_px = 1'b1;
        end else if (accept) begin
          if (!stat.full) begin
            cmd.fetch_early = 1'b1;
          end else if (!stat.pass_done) begin
            cmd.h_start = 1'b1;
            state_next = H_TAP;
          end else begin
            cmd.div_start = 1'b1;
            state_next = V_DIV;
          end
        end
      end
      H_TAP: begin
        cmd.h_tap = 1'b1;
        if (stat.tap_last) state_next = H_DRAIN;
      end
      H_DRAIN: state_next = H_MUL;
      H_MUL: begin
        cmd.mul = 1'b1;
        state_next = H_WR;
      end
      H_WR: begin
        cmd.h_write = 1'b1;
        if (stat.h_last) begin
          cmd.div_start = 1'b1;
          state_next = V_DIV;
        end else begin
          state_next = H_TAP;
        end
      end
      V_DIV: begin
        if (stat.div_done) begin
          state_next = V_TAP;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      V_TAP: begin
        cmd.v_tap = 1'b1;
        if (stat.tap_last) state_next = V_DRAIN;
      end
      V_DRAIN: state_next = V_MUL;
      V_MUL: begin
        cmd.mul = 1'b1;
        state_next = V_OUT;
      end
      V_OUT: begin
        cmd.v_out = 1'b1;
        state_next = IDLE;
      end
      default: state_next = IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

FILE: design/sbb_dp.sv
// Datapath: registers, counters, frame stores, window sums, divider, output word.
// Depends on sbb_pkg and sbb_ram.
module sbb_dp (
  input  logic                       clk,
  input  logic                       rst,
  input  sbb_pkg::sbb_cmd_t          cmd,
  output sbb_pkg::sbb_stat_t         stat,
  input  logic                       cfg_we,
  input  logic [1:0]                 cfg_index,
  input  logic [sbb_pkg::SIZE_W-1:0] cfg_data,
  input  logic [7:0]                 red_in,
  input  logic [7:0]                 green_in,
  input  logic [7:0]                 blue_in,
  input  logic                       out_ready,
  output logic                       out_valid,
  output logic [7:0]                 red_out,
  output logic [7:0]                 green_out,
  output logic [7:0]                 blue_out,
  output logic                       status,
  output logic                       last
);
  import sbb_pkg::*;

  logic [SIZE_W-1:0] width_reg, height_reg;
  logic [RAD_W-1:0]  radius_reg;
  logic [SIZE_W-1:0] w, h;
  logic [RAD_W-1:0]  r;
  logic [CNT_W-1:0]  total, load_count, fetch_count, pos;
  logic              pass_done;
  logic [COORD_W-1:0] hx, hy, vx, vy;
  logic [ADDR_W-1:0] rowbase;
  logic [TAP_W-1:0]  tap;
  logic [ACC_W-1:0]  acc_r, acc_g, acc_b;
  logic [PROD_W-1:0] prod_r, prod_g, prod_b;
  logic              rd_h, rd_v;
  logic [CNT_W-1:0]  dvd;
  logic [SIZE_W-1:0] rem;
  logic [SIZE_W:0]   rem_sh;
  logic [CNT_W-1:0]  quo;
  logic [TAP_W-1:0]  div_left;
  logic              vlast;
  logic [PIX_W-1:0]  src_rdata, hor_rdata, rd_pix, q_pix;
  logic [ADDR_W-1:0] src_raddr, hor_raddr;
  logic [COORD_W-1:0] hc, vc;
  logic [2*SIZE_W-1:0] wh;
  logic [CNT_W:0]    vaddr;
  logic [SIZE_W-1:0] rmin;
  logic [RECIP_W-1:0] m;

  always_comb begin
    w = width_reg;
    if (width_reg == '0) w = SIZE_W'(1);
    else if (width_reg > SIZE_W'(MAX_WIDTH)) w = SIZE_W'(MAX_WIDTH);
    h = height_reg;
    if (height_reg == '0) h = SIZE_W'(1);
    else if (height_reg > SIZE_W'(MAX_HEIGHT)) h = SIZE_W'(MAX_HEIGHT);
    rmin = {{(SIZE_W-RAD_W){1'b0}}, radius_reg};
    if (rmin > SIZE_W'(MAX_RADIUS)) rmin = SIZE_W'(MAX_RADIUS);
    if (rmin > w - 1'b1) rmin = w - 1'b1;
    if (rmin > h - 1'b1) rmin = h - 1'b1;
    r = rmin[RAD_W-1:0];
  end

  assign wh = w * h;
  assign total = wh[CNT_W-1:0];
  assign m = recip(r);
  assign pos = (fetch_count >= total - 1'b1) ? total - 1'b1 : fetch_count;

  assign hc = reflect(10'({2'b00, hx}) - 10'(r) + 10'(tap), w);
  assign vc = reflect(10'({2'b00, vy}) - 10'(r) + 10'(tap), h);
  assign src_raddr = rowbase + ADDR_W'(hc);
  assign vaddr = (CNT_W+1)'(vc) * (CNT_W+1)'(w) + (CNT_W+1)'(vx);
  assign hor_raddr = vaddr[ADDR_W-1:0];
  assign rd_pix = rd_h ? src_rdata : hor_rdata;
  assign rem_sh = {rem, dvd[CNT_W-1]};

  assign q_pix = {prod_r[RECIP_SHIFT +: 8], prod_g[RECIP_SHIFT +: 8],
                  prod_b[RECIP_SHIFT +: 8]};

  assign stat.full = load_count >= total;
  assign stat.pass_done = pass_done;
  assign stat.tap_last = tap == {r, 1'b0};
  assign stat.h_last = ({1'b0, hx} == w - 1'b1) && ({1'b0, hy} == h - 1'b1);
  assign stat.div_done = div_left == '0;
  assign stat.out_valid = out_valid;

  sbb_ram #(.WIDTH(PIX_W), .DEPTH(STORE_DEPTH)) u_src (
    .clk(clk), .we(cmd.load_px && !stat.full), .waddr(load_count[ADDR_W-1:0]),
    .wdata({red_in, green_in, blue_in}), .raddr(src_raddr), .rdata(src_rdata)
  );

  sbb_ram #(.WIDTH(PIX_W), .DEPTH(STORE_DEPTH)) u_hor (
    .clk(clk), .we(cmd.h_write), .waddr(rowbase + ADDR_W'(hx)),
    .wdata(q_pix), .raddr(hor_raddr), .rdata(hor_rdata)
  );

  always_ff @(posedge clk) begin
    rd_h <= cmd.h_tap;
    rd_v <= cmd.v_tap;
    if (cmd.h_start || cmd.h_write || cmd.div_start) begin
      acc_r <= '0;
      acc_g <= '0;
      acc_b <= '0;
    end else if (rd_h || rd_v) begin
      acc_r <= acc_r + ACC_W'(rd_pix[23:16]);
      acc_g <= acc_g + ACC_W'(rd_pix[15:8]);
      acc_b <= acc_b + ACC_W'(rd_pix[7:0]);
    end
    if (cmd.mul) begin
      prod_r <= PROD_W'(acc_r) * PROD_W'(m);
      prod_g <= PROD_W'(acc_g) * PROD_W'(m);
      prod_b <= PROD_W'(acc_b) * PROD_W'(m);
    end
    if (cmd.h_start || cmd.div_start) begin
      tap <= '0;
    end else if (cmd.h_tap || cmd.v_tap) begin
      tap <= stat.tap_last ? '0 : tap + 1'b1;
    end
    if (cmd.h_start) begin
      hx <= '0;
      hy <= '0;
      rowbase <= '0;
    end else if (cmd.h_write) begin
      if ({1'b0, hx} == w - 1'b1) begin
        hx <= '0;
        hy <= hy + 1'b1;
        rowbase <= rowbase + ADDR_W'(w);
      end else begin
        hx <= hx + 1'b1;
      end
    end
    if (cmd.div_start) begin
      dvd <= pos;
      rem <= '0;
      quo <= '0;
      vlast <= fetch_count >= total - 1'b1;
    end else if (cmd.div_step) begin
      dvd <= dvd << 1;
      if (rem_sh >= {1'b0, w}) begin
        rem <= SIZE_W'(rem_sh - {1'b0, w});
        quo <= {quo[CNT_W-2:0], 1'b1};
      end else begin
        rem <= rem_sh[SIZE_W-1:0];
        quo <= {quo[CNT_W-2:0], 1'b0};
      end
    end
    vx <= rem[COORD_W-1:0];
    vy <= quo[COORD_W-1:0];
    if (cmd.fetch_early) begin
      red_out <= '0;
      green_out <= '0;
      blue_out <= '0;
      status <= 1'b1;
      last <= 1'b0;
    end else if (cmd.v_out) begin
      red_out <= q_pix[23:16];
      green_out <= q_pix[15:8];
      blue_out <= q_pix[7:0];
      status <= 1'b0;
      last <= vlast;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      width_reg <= SIZE_W'(256);
      height_reg <= SIZE_W'(256);
      radius_reg <= RAD_W'(1);
      load_count <= '0;
      fetch_count <= '0;
      pass_done <= 1'b0;
      div_left <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_WIDTH: width_reg <= cfg_data;
          CFG_HEIGHT: height_reg <= cfg_data;
          CFG_RADIUS: radius_reg <= cfg_data[RAD_W-1:0];
          default: ;
        endcase
        if (cfg_index == CFG_WIDTH || cfg_index == CFG_HEIGHT ||
            cfg_index == CFG_RADIUS) begin
          pass_done <= 1'b0;
        end
      end
      if (cmd.load_px && !stat.full) load_count <= load_count + 1'b1;
      if (cmd.h_write && stat.h_last) pass_done <= 1'b1;
      if (cmd.div_start) begin
        div_left <= TAP_W'(CNT_W);
      end else if (cmd.div_step) begin
        div_left <= div_left - 1'b1;
      end
      if (cmd.v_out) begin
        if (vlast) begin
          load_count <= '0;
          fetch_count <= '0;
          pass_done <= 1'b0;
        end else begin
          fetch_count <= fetch_count + 1'b1;
        end
      end
      if (cmd.fetch_early || cmd.v_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

FILE: design/separable_box_blur_frame.sv
// Top level of the separable box blur: joins the controller and the datapath.
// Depends on sbb_pkg, sbb_ctrl, sbb_dp and sbb_ram.
//
// A load stores one pixel while the frame is not yet full. A fetch made before
// the frame is fully loaded answers in the next cycle with status set. The
// first ready fetch after a load or a width, height or radius write first runs
// the horizontal pass: each pixel reads 2r+1 source words one per cycle from
// the frame store's single read port, then passes the drain, multiply and
// write states to finish the sum, scale and write it. Every fetch then runs
// the position divider, the 2r+1 column reads and the drain, multiply and
// output states to finish the sum, scale and register the word. A new request
// is accepted once the controller is idle and the output word is free or is
// being taken.
module separable_box_blur_frame (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       action,
  input  logic [7:0] red_in,
  input  logic [7:0] green_in,
  input  logic [7:0] blue_in,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] red_out,
  output logic [7:0] green_out,
  output logic [7:0] blue_out,
  output logic       status,
  output logic       last,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [sbb_pkg::SIZE_W-1:0] cfg_data
);
  import sbb_pkg::*;

  sbb_cmd_t  cmd;
  sbb_stat_t stat;

  assign cfg_ready = 1'b1;

  sbb_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .action(action),
    .out_ready(out_ready), .stat(stat), .in_ready(in_ready), .cmd(cmd)
  );

  sbb_dp u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat),
    .cfg_we(cfg_valid && cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .red_in(red_in), .green_in(green_in), .blue_in(blue_in),
    .out_ready(out_ready), .out_valid(out_valid),
    .red_out(red_out), .green_out(green_out), .blue_out(blue_out),
    .status(status), .last(last)
  );

endmodule
